/* sv/plcr_pkg.sv */
// ----------------------------------------------------------------------------
// plcr_pkg: shared types and constants of the polyline colinear point remover
// Payload structs, sequencer and phase enums, multiplier op bundle and the
// derived widths of the limb-split squared-distance arithmetic.
// ----------------------------------------------------------------------------
package plcr_pkg;

   // Coordinate format: signed 16.8 fixed point
   localparam int COORD_BITS = 24;
   localparam int TOL_W      = 16;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(256);

   // Shared multiplier: one limb plus one extra bit per operand
   localparam int LIMB_W = (COORD_BITS > TOL_W) ? COORD_BITS : TOL_W;
   localparam int MUL_W  = LIMB_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   // Cross product magnitude and tol*|d| both fit in two limbs plus one bit
   localparam int CR_W   = 2 * LIMB_W + 1;
   // Signed accumulator holding tol^2*L2 - cross^2 without overflow
   localparam int ACC_W  = 4 * LIMB_W + 3;
   localparam int STEP_W = 4;

   typedef enum logic [1:0] {
      PH_EMPTY = 2'd0,
      PH_ONE   = 2'd1,
      PH_LINE  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_SHIFT,
      ST_FLUSH_A,
      ST_FLUSH_E
   } state_type;

   // Left shift applied to a product before accumulation
   typedef enum logic [1:0] {
      SH_NONE,
      SH_MID,
      SH_HIGH
   } shift_type;

   typedef struct packed {
      logic                         cmd;
      logic signed [COORD_BITS-1:0] pt_x;
      logic signed [COORD_BITS-1:0] pt_y;
   } plcr_req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic                         last_of_run;
   } plcr_rsp_type;

   // One issue slot of the shared multiply-accumulate unit
   typedef struct packed {
      logic             en;
      logic             clr;
      logic             sub;
      shift_type        shift;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } plcr_mul_op_type;

   // Magnitude of a coordinate difference (fits in COORD_BITS)
   function automatic logic [COORD_BITS-1:0] mag_of(input logic signed [COORD_BITS:0] v);
      logic signed [COORD_BITS:0] n;
      n = v[COORD_BITS] ? -v : v;
      return n[COORD_BITS-1:0];
   endfunction

   function automatic logic [MUL_W-1:0] widen_coord(input logic [COORD_BITS-1:0] v);
      return {{(MUL_W-COORD_BITS){1'b0}}, v};
   endfunction

   function automatic logic [MUL_W-1:0] widen_tol(input logic [TOL_W-1:0] v);
      return {{(MUL_W-TOL_W){1'b0}}, v};
   endfunction

   function automatic logic [MUL_W-1:0] limb_lo(input logic [CR_W-1:0] v);
      return {{(MUL_W-LIMB_W){1'b0}}, v[LIMB_W-1:0]};
   endfunction

   function automatic logic [MUL_W-1:0] limb_hi(input logic [CR_W-1:0] v);
      return v[CR_W-1:LIMB_W];
   endfunction

   // Magnitude of the accumulator, cut to the cross product width
   function automatic logic [CR_W-1:0] acc_mag(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] n;
      n = v[ACC_W-1] ? -v : v;
      return n[CR_W-1:0];
   endfunction

endpackage

/* sv/plcr_mul_unit.sv */
// ----------------------------------------------------------------------------
// plcr_mul_unit: shared multiply-accumulate unit
// Stage one registers an unsigned MUL_W x MUL_W product, stage two shifts it
// by a limb offset and adds it to or subtracts it from a signed accumulator.
// ----------------------------------------------------------------------------
module plcr_mul_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  plcr_pkg::plcr_mul_op_type              op,
   output logic [plcr_pkg::PROD_W-1:0]            prod,
   output logic signed [plcr_pkg::ACC_W-1:0]      acc
);

   logic [plcr_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic                              en_ff, en_in;
   logic                              clr_ff, clr_in;
   logic                              sub_ff, sub_in;
   plcr_pkg::shift_type               shift_ff, shift_in;
   logic [plcr_pkg::ACC_W-1:0]        ext, shifted;
   logic signed [plcr_pkg::ACC_W-1:0] acc_ff, acc_in, base;

   // Multiply stage
   assign prod_in  = {{plcr_pkg::MUL_W{1'b0}}, op.a} * {{plcr_pkg::MUL_W{1'b0}}, op.b};
   assign en_in    = op.en;
   assign clr_in   = op.clr;
   assign sub_in   = op.sub;
   assign shift_in = op.shift;

   // Accumulate stage: align the product to its limb position
   assign ext = {{(plcr_pkg::ACC_W-plcr_pkg::PROD_W){1'b0}}, prod_ff};

   always_comb begin
      case (shift_ff)
         plcr_pkg::SH_NONE: shifted = ext;
         plcr_pkg::SH_MID:  shifted = ext << (plcr_pkg::LIMB_W + 1);
         plcr_pkg::SH_HIGH: shifted = ext << (2 * plcr_pkg::LIMB_W);
         default:           shifted = ext;
      endcase
   end

   always_comb begin
      base   = clr_ff ? '0 : acc_ff;
      acc_in = acc_ff;
      if (en_ff) begin
         acc_in = sub_ff ? (base - $signed(shifted)) : (base + $signed(shifted));
      end
   end

   // Hold the enable with reset; product, clear, subtract, shift and accumulator without
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
      end else begin
         en_ff <= en_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      clr_ff   <= clr_in;
      sub_ff   <= sub_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

/* sv/plcr_seq.sv */
// ----------------------------------------------------------------------------
// plcr_seq: point sequencer
// Holds phase, anchor and end points, steps the micro-program that feeds the
// shared multiply-accumulate unit, decides keep or shift, and emits points.
// ----------------------------------------------------------------------------
module plcr_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  plcr_pkg::plcr_req_type                req_payload,
   input  logic [plcr_pkg::TOL_W-1:0]            tol,
   input  logic                                  out_free,
   output logic                                  out_load,
   output plcr_pkg::plcr_rsp_type                out_data,
   output plcr_pkg::plcr_mul_op_type             op,
   input  logic [plcr_pkg::PROD_W-1:0]           prod,
   input  logic signed [plcr_pkg::ACC_W-1:0]     acc
);

   localparam logic [plcr_pkg::STEP_W-1:0] STEP_CAP_CR = 4'd3;
   localparam logic [plcr_pkg::STEP_W-1:0] STEP_CAP_V  = 4'd4;
   localparam logic [plcr_pkg::STEP_W-1:0] ONE_DONE    = 4'd4;
   localparam logic [plcr_pkg::STEP_W-1:0] LINE_DONE   = 4'd14;

   plcr_pkg::state_type                 state_ff, state_in;
   plcr_pkg::phase_type                 phase_ff, phase_in;
   logic [plcr_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [plcr_pkg::COORD_BITS-1:0]     anchor_x_ff, anchor_x_in, anchor_y_ff, anchor_y_in;
   logic [plcr_pkg::COORD_BITS-1:0]     end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic [plcr_pkg::COORD_BITS-1:0]     pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic [plcr_pkg::CR_W-1:0]           cr_ff, cr_in, u_ff, u_in, v_ff, v_in;

   logic signed [plcr_pkg::COORD_BITS:0] sx, sy, qx, qy;
   logic [plcr_pkg::COORD_BITS-1:0]      sx_m, sy_m, qx_m, qy_m;
   logic [plcr_pkg::MUL_W-1:0]           tol_w;
   logic                                 na, nb, acc_pos;

   // Segment and point offsets from the anchor
   always_comb begin
      sx = {end_x_ff[plcr_pkg::COORD_BITS-1], end_x_ff}
         - {anchor_x_ff[plcr_pkg::COORD_BITS-1], anchor_x_ff};
      sy = {end_y_ff[plcr_pkg::COORD_BITS-1], end_y_ff}
         - {anchor_y_ff[plcr_pkg::COORD_BITS-1], anchor_y_ff};
      qx = {pt_x_ff[plcr_pkg::COORD_BITS-1], pt_x_ff}
         - {anchor_x_ff[plcr_pkg::COORD_BITS-1], anchor_x_ff};
      qy = {pt_y_ff[plcr_pkg::COORD_BITS-1], pt_y_ff}
         - {anchor_y_ff[plcr_pkg::COORD_BITS-1], anchor_y_ff};
      sx_m = plcr_pkg::mag_of(sx);
      sy_m = plcr_pkg::mag_of(sy);
      qx_m = plcr_pkg::mag_of(qx);
      qy_m = plcr_pkg::mag_of(qy);
      na   = sx[plcr_pkg::COORD_BITS] ^ qy[plcr_pkg::COORD_BITS];
      nb   = sy[plcr_pkg::COORD_BITS] ^ qx[plcr_pkg::COORD_BITS];
      tol_w = plcr_pkg::widen_tol(tol);
   end

   assign acc_pos = !acc[plcr_pkg::ACC_W-1] && (acc != '0);

   // Micro-program: issue one product per step into the shared unit.
   // Line phase builds cross = sx*qy - sy*qx, then
   // acc = (tol*sx)^2 + (tol*sy)^2 - cross^2 over limb products.
   // One-point phase builds acc = qx^2 + qy^2 - tol^2.
   always_comb begin
      op = '0;
      if (state_ff == plcr_pkg::ST_CALC) begin
         if (phase_ff == plcr_pkg::PH_LINE) begin
            case (step_ff)
               4'd0: begin
                  op.a = plcr_pkg::widen_coord(sx_m); op.b = plcr_pkg::widen_coord(qy_m);
                  op.en = 1'b1; op.clr = 1'b1; op.sub = na;
               end
               4'd1: begin
                  op.a = plcr_pkg::widen_coord(sy_m); op.b = plcr_pkg::widen_coord(qx_m);
                  op.en = 1'b1; op.sub = !nb;
               end
               4'd2: begin
                  op.a = tol_w; op.b = plcr_pkg::widen_coord(sx_m);
               end
               4'd3: begin
                  op.a = tol_w; op.b = plcr_pkg::widen_coord(sy_m);
               end
               4'd4: begin
                  op.a = plcr_pkg::limb_lo(cr_ff); op.b = plcr_pkg::limb_lo(cr_ff);
                  op.en = 1'b1; op.clr = 1'b1; op.sub = 1'b1;
               end
               4'd5: begin
                  op.a = plcr_pkg::limb_lo(cr_ff); op.b = plcr_pkg::limb_hi(cr_ff);
                  op.en = 1'b1; op.sub = 1'b1; op.shift = plcr_pkg::SH_MID;
               end
               4'd6: begin
                  op.a = plcr_pkg::limb_hi(cr_ff); op.b = plcr_pkg::limb_hi(cr_ff);
                  op.en = 1'b1; op.sub = 1'b1; op.shift = plcr_pkg::SH_HIGH;
               end
               4'd7: begin
                  op.a = plcr_pkg::limb_lo(u_ff); op.b = plcr_pkg::limb_lo(u_ff);
                  op.en = 1'b1;
               end
               4'd8: begin
                  op.a = plcr_pkg::limb_lo(u_ff); op.b = plcr_pkg::limb_hi(u_ff);
                  op.en = 1'b1; op.shift = plcr_pkg::SH_MID;
               end
               4'd9: begin
                  op.a = plcr_pkg::limb_hi(u_ff); op.b = plcr_pkg::limb_hi(u_ff);
                  op.en = 1'b1; op.shift = plcr_pkg::SH_HIGH;
               end
               4'd10: begin
                  op.a = plcr_pkg::limb_lo(v_ff); op.b = plcr_pkg::limb_lo(v_ff);
                  op.en = 1'b1;
               end
               4'd11: begin
                  op.a = plcr_pkg::limb_lo(v_ff); op.b = plcr_pkg::limb_hi(v_ff);
                  op.en = 1'b1; op.shift = plcr_pkg::SH_MID;
               end
               4'd12: begin
                  op.a = plcr_pkg::limb_hi(v_ff); op.b = plcr_pkg::limb_hi(v_ff);
                  op.en = 1'b1; op.shift = plcr_pkg::SH_HIGH;
               end
               default: op = '0;
            endcase
         end else begin
            case (step_ff)
               4'd0: begin
                  op.a = plcr_pkg::widen_coord(qx_m); op.b = plcr_pkg::widen_coord(qx_m);
                  op.en = 1'b1; op.clr = 1'b1;
               end
               4'd1: begin
                  op.a = plcr_pkg::widen_coord(qy_m); op.b = plcr_pkg::widen_coord(qy_m);
                  op.en = 1'b1;
               end
               4'd2: begin
                  op.a = tol_w; op.b = tol_w;
                  op.en = 1'b1; op.sub = 1'b1;
               end
               default: op = '0;
            endcase
         end
      end
   end

   // Next state, point registers and result loading
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      step_in     = step_ff;
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      end_x_in    = end_x_ff;
      end_y_in    = end_y_ff;
      pt_x_in     = pt_x_ff;
      pt_y_in     = pt_y_ff;
      cr_in       = cr_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      req_ready   = 1'b0;
      out_load    = 1'b0;
      out_data    = '0;

      case (state_ff)
         plcr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               step_in = '0;
               if (req_payload.cmd) begin
                  case (phase_ff)
                     plcr_pkg::PH_ONE, plcr_pkg::PH_LINE: state_in = plcr_pkg::ST_FLUSH_A;
                     default: phase_in = plcr_pkg::PH_EMPTY;
                  endcase
               end else begin
                  pt_x_in = req_payload.pt_x;
                  pt_y_in = req_payload.pt_y;
                  case (phase_ff)
                     plcr_pkg::PH_ONE, plcr_pkg::PH_LINE: state_in = plcr_pkg::ST_CALC;
                     default: begin
                        anchor_x_in = req_payload.pt_x;
                        anchor_y_in = req_payload.pt_y;
                        phase_in    = plcr_pkg::PH_ONE;
                     end
                  endcase
               end
            end
         end

         plcr_pkg::ST_CALC: begin
            step_in = step_ff + 1'b1;
            if (phase_ff == plcr_pkg::PH_LINE) begin
               // capture cross magnitude and tol*|sx|, then tol*|sy|
               if (step_ff == STEP_CAP_CR) begin
                  cr_in = plcr_pkg::acc_mag(acc);
                  u_in  = prod[plcr_pkg::CR_W-1:0];
               end
               if (step_ff == STEP_CAP_V) begin
                  v_in = prod[plcr_pkg::CR_W-1:0];
               end
               if (step_ff == LINE_DONE) begin
                  if (acc_pos) begin
                     end_x_in = pt_x_ff;
                     end_y_in = pt_y_ff;
                     state_in = plcr_pkg::ST_IDLE;
                  end else begin
                     state_in = plcr_pkg::ST_SHIFT;
                  end
               end
            end else if (step_ff == ONE_DONE) begin
               if (acc_pos) begin
                  end_x_in = pt_x_ff;
                  end_y_in = pt_y_ff;
                  phase_in = plcr_pkg::PH_LINE;
               end
               state_in = plcr_pkg::ST_IDLE;
            end
         end

         plcr_pkg::ST_SHIFT: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_data.out_x       = anchor_x_ff;
               out_data.out_y       = anchor_y_ff;
               out_data.last_of_run = 1'b1;
               anchor_x_in          = end_x_ff;
               anchor_y_in          = end_y_ff;
               end_x_in             = pt_x_ff;
               end_y_in             = pt_y_ff;
               state_in             = plcr_pkg::ST_IDLE;
            end
         end

         plcr_pkg::ST_FLUSH_A: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_data.out_x       = anchor_x_ff;
               out_data.out_y       = anchor_y_ff;
               out_data.last_of_run = (phase_ff != plcr_pkg::PH_LINE);
               if (phase_ff == plcr_pkg::PH_LINE) begin
                  state_in = plcr_pkg::ST_FLUSH_E;
               end else begin
                  phase_in = plcr_pkg::PH_EMPTY;
                  state_in = plcr_pkg::ST_IDLE;
               end
            end
         end

         plcr_pkg::ST_FLUSH_E: begin
            if (out_free) begin
               out_load             = 1'b1;
               out_data.out_x       = end_x_ff;
               out_data.out_y       = end_y_ff;
               out_data.last_of_run = 1'b1;
               phase_in             = plcr_pkg::PH_EMPTY;
               state_in             = plcr_pkg::ST_IDLE;
            end
         end

         default: state_in = plcr_pkg::ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plcr_pkg::ST_IDLE;
         phase_ff <= plcr_pkg::PH_EMPTY;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   // Point and operand registers
   always_ff @(posedge clock) begin
      anchor_x_ff <= anchor_x_in;
      anchor_y_ff <= anchor_y_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      cr_ff       <= cr_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
   end

endmodule

/* sv/polyline_colinear_point_remover_unit.sv */
// ----------------------------------------------------------------------------
// polyline_colinear_point_remover_unit: streaming polyline simplifier
// Drops points closer than the tolerance to the line through the kept anchor
// and end point; emits anchors as the line shifts and the rest on a flush.
// ----------------------------------------------------------------------------
//
//   port group   direction   flow control     carries
//   req_*        in          valid / ready    plcr_req_type (cmd, pt_x, pt_y)
//   rsp_*        out         valid / ready    plcr_rsp_type (out_x, out_y, last)
//   csr_*        in          write enable     tolerance, 16 bit
//
// A push in empty phase only records the anchor; in the other phases the
// sequencer runs the multiplier micro-program, and in line phase it may emit
// the anchor; a flush emits up to two points. In line phase the single shared
// two-stage multiply-accumulate pipeline takes 13 products, one per cycle.
// Reset is synchronous: phase returns to empty, tolerance to 256.
// A stalled result sits in the output register; the next item is still
// accepted, and the sequencer waits only when it has a new point to emit.
//
module polyline_colinear_point_remover_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  plcr_pkg::plcr_req_type            req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output plcr_pkg::plcr_rsp_type            rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [plcr_pkg::TOL_W-1:0]        csr_wr_data
);

   logic [plcr_pkg::TOL_W-1:0]        tol_ff, tol_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   plcr_pkg::plcr_rsp_type            rsp_ff, rsp_in;
   logic                              out_free, out_load;
   plcr_pkg::plcr_rsp_type            out_data;
   plcr_pkg::plcr_mul_op_type         mul_op;
   logic [plcr_pkg::PROD_W-1:0]       prod;
   logic signed [plcr_pkg::ACC_W-1:0] acc;

   // Tolerance register
   assign tol_in = csr_wr_en ? csr_wr_data : tol_ff;

   // Output register: load a new result when empty or drained this cycle
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_in       = out_load ? out_data : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= plcr_pkg::TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   plcr_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .tol         (tol_ff),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_data    (out_data),
      .op          (mul_op),
      .prod        (prod),
      .acc         (acc)
   );

   plcr_mul_unit u_mul (
      .clock (clock),
      .reset (reset),
      .op    (mul_op),
      .prod  (prod),
      .acc   (acc)
   );

endmodule
